FILE: hw/rtl/lcbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbb_pkg
// Shared types for the LRU cache with byte budget: command and result codes,
// datapath operations and the control/status bundles between the two halves.
// ----------------------------------------------------------------------------
package lcbb_pkg;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RES_FIND    = 2'd0,
    RES_RELEASE = 2'd1,
    RES_DONE    = 2'd2
  } res_kind_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_SCAN_RD,
    DP_SCAN_CMP,
    DP_FIND_EMIT,
    DP_RD_VICTIM,
    DP_RD_OLDEST,
    DP_RD_RANK,
    DP_COMMIT,
    DP_CLR_PUSH,
    DP_PLACE,
    DP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FIND_EMIT,
    S_EV_RD,
    S_EV_CM,
    S_FULL_CHK,
    S_FULL_CM,
    S_PLACE,
    S_OVER_CHK,
    S_OVER_CM,
    S_CLR_RD,
    S_CLR_EMIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic match_now;
    logic scan_last;
    logic full;
    logic over;
    logic clr_done;
  } dp_stat_t;

endpackage

FILE: hw/rtl/lcbb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcbb_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lcbb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbb_ctrl
// Sequencer: walks each command through key scan, evictions, placement,
// clear walk and result flush by issuing at most one datapath operation a cycle.
// ----------------------------------------------------------------------------
module lcbb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        command_i,
  input  lcbb_pkg::dp_stat_t stat_i,
  output lcbb_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o
);
  import lcbb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = DP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = DP_LOAD;
          unique case (cmd_e'(command_i))
            CMD_FIND, CMD_INSERT: state_d = S_SCAN_RD;
            CMD_CLEAR:            state_d = S_CLR_RD;
            CMD_NOP:              state_d = S_FINISH;
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd_o.op = DP_SCAN_RD;
        state_d  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd_o.op = DP_SCAN_CMP;
        if (stat_i.match_now) begin
          state_d = (stat_i.cmd == CMD_FIND) ? S_FIND_EMIT : S_EV_RD;
        end else if (stat_i.scan_last) begin
          state_d = (stat_i.cmd == CMD_FIND) ? S_FIND_EMIT : S_FULL_CHK;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_FIND_EMIT: begin
        cmd_o.op = DP_FIND_EMIT;
        state_d  = S_IDLE;
      end
      S_EV_RD: begin
        cmd_o.op = DP_RD_VICTIM;
        state_d  = S_EV_CM;
      end
      S_EV_CM: begin
        cmd_o.op = DP_COMMIT;
        state_d  = S_FULL_CHK;
      end
      S_FULL_CHK: begin
        if (stat_i.full) begin
          cmd_o.op = DP_RD_OLDEST;
          state_d  = S_FULL_CM;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_FULL_CM: begin
        cmd_o.op = DP_COMMIT;
        state_d  = S_PLACE;
      end
      S_PLACE: begin
        cmd_o.op = DP_PLACE;
        state_d  = S_OVER_CHK;
      end
      S_OVER_CHK: begin
        if (stat_i.over) begin
          cmd_o.op = DP_RD_OLDEST;
          state_d  = S_OVER_CM;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_OVER_CM: begin
        cmd_o.op = DP_COMMIT;
        state_d  = S_OVER_CHK;
      end
      S_CLR_RD: begin
        if (stat_i.clr_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.op = DP_RD_RANK;
          state_d  = S_CLR_EMIT;
        end
      end
      S_CLR_EMIT: begin
        cmd_o.op = DP_CLR_PUSH;
        state_d  = S_CLR_RD;
      end
      S_FINISH: begin
        cmd_o.op = DP_FINISH;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: hw/rtl/lcbb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbb_dp
// Datapath: slot RAM (key, handle, bytes), per-slot valid and age rank flops,
// entry count, byte total, one pending release word and the result register.
// ----------------------------------------------------------------------------
module lcbb_dp #(
  parameter int ENTRIES     = 32,
  parameter int MAX_DIM     = 8192,
  parameter int HANDLE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcbb_pkg::dp_cmd_t  cmd_i,
  output lcbb_pkg::dp_stat_t stat_o,
  input  logic [1:0]         command_i,
  input  logic [63:0]        key_i,
  input  logic [31:0]        handle_i,
  input  logic [13:0]        width_i,
  input  logic [13:0]        height_i,
  input  logic [5:0]         max_entries_i,
  input  logic [31:0]        max_bytes_i,
  output logic               result_valid_o,
  output logic [1:0]         result_kind_o,
  output logic               hit_o,
  output logic [31:0]        out_handle_o,
  output logic [63:0]        out_key_o,
  output logic               last_o
);
  import lcbb_pkg::*;

  localparam int IW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int DIMW = $clog2(MAX_DIM + 1);
  localparam int BW   = 2 * DIMW + 2;
  localparam int TW   = BW + CW;
  localparam int HB   = HANDLE_BITS;
  localparam int RAMW = 64 + HB + BW;

  // payload
  cmd_e            cmd_q;
  logic [63:0]     key_q;
  logic [HB-1:0]   hnd_q;
  logic [BW-1:0]   bytes_q;
  logic [IW-1:0]   vslot_q;
  logic [HB-1:0]   hit_hnd_q;
  logic [HB-1:0]   pend_hnd_q;
  logic [63:0]     pend_key_q;
  res_kind_e       out_kind_q;
  logic            out_hit_q;
  logic [HB-1:0]   out_hnd_q;
  logic [63:0]     out_key_q;
  logic            out_last_q;

  // control
  logic [ENTRIES-1:0] valid_q;
  logic [IW-1:0]      rank_q [ENTRIES];
  logic [CW-1:0]      count_q;
  logic [TW-1:0]      total_q;
  logic [CW-1:0]      idx_q;
  logic               match_q;
  logic               pend_v_q;
  logic               out_v_q;

  logic [IW-1:0]   scan_idx, old_idx, free_idx, rank_idx, raddr, vrank;
  logic [RAMW-1:0] rdata;
  logic [63:0]     rd_key;
  logic [HB-1:0]   rd_hnd;
  logic [BW-1:0]   rd_bytes;
  logic            re;
  logic [DIMW-1:0] w_sat, h_sat;
  logic [2*DIMW-1:0] prod;
  logic [7:0]      lim8;

  assign scan_idx = idx_q[IW-1:0];
  assign rd_key   = rdata[RAMW-1 -: 64];
  assign rd_hnd   = rdata[BW +: HB];
  assign rd_bytes = rdata[BW-1:0];
  assign vrank    = rank_q[vslot_q];

  always_comb begin
    old_idx  = '0;
    rank_idx = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && (CW'(rank_q[i]) == count_q - CW'(1))) old_idx = IW'(i);
      if (valid_q[i] && (CW'(rank_q[i]) == idx_q)) rank_idx = IW'(i);
    end
    // lowest free slot wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IW'(i);
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = vslot_q;
    unique case (cmd_i.op)
      DP_SCAN_RD:   begin re = 1'b1; raddr = scan_idx; end
      DP_RD_VICTIM: begin re = 1'b1; raddr = vslot_q;  end
      DP_RD_OLDEST: begin re = 1'b1; raddr = old_idx;  end
      DP_RD_RANK:   begin re = 1'b1; raddr = rank_idx; end
      default:      ;
    endcase
  end

  lcbb_ram #(
    .Width (RAMW),
    .Depth (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == DP_PLACE),
    .waddr_i (free_idx),
    .wdata_i ({key_q, hnd_q, bytes_q}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign w_sat = (32'(width_i) > 32'(MAX_DIM))  ? DIMW'(MAX_DIM) : DIMW'(width_i);
  assign h_sat = (32'(height_i) > 32'(MAX_DIM)) ? DIMW'(MAX_DIM) : DIMW'(height_i);
  assign prod  = (2 * DIMW)'(w_sat) * (2 * DIMW)'(h_sat);
  assign lim8  = (8'(max_entries_i) < 8'(ENTRIES)) ? 8'(max_entries_i) : 8'(ENTRIES);

  assign stat_o.cmd       = cmd_q;
  assign stat_o.match_now = valid_q[scan_idx] && (rd_key == key_q);
  assign stat_o.scan_last = (scan_idx == IW'(ENTRIES - 1));
  assign stat_o.full      = (count_q >= CW'(ENTRIES));
  assign stat_o.over      = (count_q != '0) &&
                            ((8'(count_q) > lim8) || (64'(total_q) > 64'(max_bytes_i)));
  assign stat_o.clr_done  = (idx_q == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
      count_q  <= '0;
      total_q  <= '0;
      idx_q    <= '0;
      match_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      out_v_q <= 1'b0;
      unique case (cmd_i.op)
        DP_LOAD: begin
          idx_q   <= '0;
          match_q <= 1'b0;
        end
        DP_SCAN_CMP: begin
          if (stat_o.match_now) match_q <= 1'b1;
          idx_q <= idx_q + CW'(1);
        end
        DP_FIND_EMIT: begin
          out_v_q <= 1'b1;
          if (match_q) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_q[i] && rank_q[i] < vrank) rank_q[i] <= rank_q[i] + IW'(1);
            end
            rank_q[vslot_q] <= '0;
          end
        end
        DP_COMMIT: begin
          pend_v_q <= 1'b1;
          if (pend_v_q) out_v_q <= 1'b1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && rank_q[i] > vrank) rank_q[i] <= rank_q[i] - IW'(1);
          end
          rank_q[vslot_q]  <= '0;
          valid_q[vslot_q] <= 1'b0;
          if (count_q != '0) count_q <= count_q - CW'(1);
          total_q <= (total_q >= TW'(rd_bytes)) ? total_q - TW'(rd_bytes) : '0;
        end
        DP_CLR_PUSH: begin
          pend_v_q <= 1'b1;
          if (pend_v_q) out_v_q <= 1'b1;
          idx_q <= idx_q + CW'(1);
        end
        DP_PLACE: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i]) rank_q[i] <= rank_q[i] + IW'(1);
          end
          rank_q[free_idx]  <= '0;
          valid_q[free_idx] <= 1'b1;
          count_q <= count_q + CW'(1);
          total_q <= total_q + TW'(bytes_q);
        end
        DP_FINISH: begin
          out_v_q  <= 1'b1;
          pend_v_q <= 1'b0;
          if (cmd_q == CMD_CLEAR) begin
            valid_q <= '0;
            for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
            count_q <= '0;
            total_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        cmd_q   <= cmd_e'(command_i);
        key_q   <= key_i;
        hnd_q   <= HB'(64'(handle_i));
        bytes_q <= {prod, 2'b00};
      end
      DP_SCAN_CMP: begin
        if (stat_o.match_now) begin
          vslot_q   <= scan_idx;
          hit_hnd_q <= rd_hnd;
        end
      end
      DP_RD_OLDEST: vslot_q <= old_idx;
      DP_FIND_EMIT: begin
        out_kind_q <= RES_FIND;
        out_hit_q  <= match_q;
        out_hnd_q  <= match_q ? hit_hnd_q : '0;
        out_key_q  <= match_q ? key_q : '0;
        out_last_q <= 1'b1;
      end
      DP_COMMIT, DP_CLR_PUSH: begin
        // previous release goes out now that another one follows it
        out_kind_q <= RES_RELEASE;
        out_hit_q  <= 1'b0;
        out_hnd_q  <= pend_hnd_q;
        out_key_q  <= pend_key_q;
        out_last_q <= 1'b0;
        pend_hnd_q <= rd_hnd;
        pend_key_q <= rd_key;
      end
      DP_FINISH: begin
        out_kind_q <= pend_v_q ? RES_RELEASE : RES_DONE;
        out_hit_q  <= 1'b0;
        out_hnd_q  <= pend_v_q ? pend_hnd_q : '0;
        out_key_q  <= pend_v_q ? pend_key_q : '0;
        out_last_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign result_valid_o = out_v_q;
  assign result_kind_o  = out_kind_q;
  assign hit_o          = out_hit_q;
  assign out_handle_o   = 32'(64'(out_hnd_q));
  assign out_key_o      = out_key_q;
  assign last_o         = out_last_q;

endmodule

FILE: hw/rtl/lru_cache_with_byte_budget_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_with_byte_budget_core
// Fully associative LRU cache with an entry limit and a byte budget.
// ----------------------------------------------------------------------------
// One command is taken at a time (start while busy is low). Keys are held in a
// slot RAM with one read port and searched one slot at a time, read then
// compared; a find stops early on a hit. An insert then drops an old copy of the
// key, drops the oldest entry if full, places the entry and drops oldest entries
// while over a limit; a clear releases each held entry. Each result is shown for
// exactly one cycle on result_valid_o and must be taken then; the receiver cannot
// stall the block. Each release is held back until the next one is known or the
// command ends, so the final word of a command always carries last_o.
module lru_cache_with_byte_budget_core #(
  parameter int ENTRIES     = 32,
  parameter int MAX_DIM     = 8192,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [63:0] key_i,
  input  logic [31:0] handle_i,
  input  logic [13:0] width_i,
  input  logic [13:0] height_i,
  output logic        result_valid_o,
  output logic [1:0]  result_kind_o,
  output logic        hit_o,
  output logic [31:0] out_handle_o,
  output logic [63:0] out_key_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lcbb_pkg::*;

  localparam logic [5:0]  MaxEntriesRst = 6'd32;
  localparam logic [31:0] MaxBytesRst   = 32'd100663296;

  logic [5:0]  max_entries_q;
  logic [31:0] max_bytes_q;
  dp_cmd_t     dp_cmd;
  dp_stat_t    dp_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MaxEntriesRst;
      max_bytes_q   <= MaxBytesRst;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        max_bytes_q <= pwdata;
      end else begin
        max_entries_q <= pwdata[5:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? max_bytes_q : {26'd0, max_entries_q};

  lcbb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .busy_o    (busy)
  );

  lcbb_dp #(
    .ENTRIES     (ENTRIES),
    .MAX_DIM     (MAX_DIM),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .command_i      (command_i),
    .key_i          (key_i),
    .handle_i       (handle_i),
    .width_i        (width_i),
    .height_i       (height_i),
    .max_entries_i  (max_entries_q),
    .max_bytes_i    (max_bytes_q),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .hit_o          (hit_o),
    .out_handle_o   (out_handle_o),
    .out_key_o      (out_key_o),
    .last_o         (last_o)
  );

endmodule

FILE: hw/rtl/lcbb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbb_checker
// Port-level checks on result words of the LRU cache core.
// ----------------------------------------------------------------------------
module lcbb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [1:0]  result_kind_o,
  input logic        hit_o,
  input logic [31:0] out_handle_o,
  input logic        last_o
);
  import lcbb_pkg::*;

  // a command never answers in the cycle right after it is taken
  a_no_early_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result word right after accept");

  a_find_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_kind_o == RES_FIND) |-> last_o)
    else $error("find answer not final");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_kind_o == RES_DONE) |-> (last_o && !hit_o && out_handle_o == '0))
    else $error("bad done word");

  a_release_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_kind_o == RES_RELEASE) |-> !hit_o)
    else $error("release with hit set");

  // a final word is never directly followed by another word
  a_last_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("word follows final word");

endmodule

bind lru_cache_with_byte_budget_core lcbb_checker u_lcbb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_kind_o  (result_kind_o),
  .hit_o          (hit_o),
  .out_handle_o   (out_handle_o),
  .last_o         (last_o)
);

FILE: tb/lcbb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbb_scoreboard
// Watches the command and result channels of the LRU cache, keeps its own
// copy of the cache contents and limits, and compares every result word.
// ----------------------------------------------------------------------------
module lcbb_scoreboard #(
  parameter int ENTRIES     = 32,
  parameter int MAX_DIM     = 8192,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  command_i,
  input  logic [63:0] key_i,
  input  logic [31:0] handle_i,
  input  logic [13:0] width_i,
  input  logic [13:0] height_i,
  input  logic        result_valid_o,
  input  logic [1:0]  result_kind_o,
  input  logic        hit_o,
  input  logic [31:0] out_handle_o,
  input  logic [63:0] out_key_o,
  input  logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_words
);
  import lcbb_pkg::*;

  typedef struct packed {
    res_kind_e   kind;
    logic        hit;
    logic [31:0] handle;
    logic [63:0] key;
    logic        last;
  } word_t;

  localparam logic [2:0] ADDR_MAX_ENTRIES = 3'd0;
  localparam logic [2:0] ADDR_MAX_BYTES   = 3'd4;
  localparam logic [63:0] HANDLE_MASK =
    (HANDLE_BITS >= 64) ? '1 : ((64'd1 << HANDLE_BITS) - 64'd1);

  word_t       expected_words[$];
  logic [5:0]  lim_entries;
  logic [31:0] lim_bytes;
  logic [63:0] c_key[ENTRIES];
  logic [31:0] c_handle[ENTRIES];
  logic [33:0] c_bytes[ENTRIES];
  logic        c_valid[ENTRIES];
  int          c_rank[ENTRIES];
  int          c_count;
  logic [33:0] c_total;

  assign pending_words = expected_words.size();

  function automatic void push_word(res_kind_e k, logic h, logic [31:0] hd,
                                    logic [63:0] ky);
    word_t w;
    w.kind = k; w.hit = h; w.handle = hd; w.key = ky; w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (c_valid[i] && (best < 0 || c_rank[i] > c_rank[best])) best = i;
    return best;
  endfunction

  function automatic void drop_slot(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (c_valid[i] && c_rank[i] > c_rank[s]) c_rank[i]--;
    c_valid[s] = 1'b0;
    c_rank[s] = 0;
    if (c_count > 0) c_count--;
    c_total = (c_total >= c_bytes[s]) ? c_total - c_bytes[s] : '0;
    push_word(RES_RELEASE, 1'b0, c_handle[s], c_key[s]);
  endfunction

  function automatic int lookup(logic [63:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (c_valid[i] && c_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void predict_cache(cmd_e cmd, logic [63:0] k, logic [31:0] hd,
                                        logic [13:0] wd, logic [13:0] ht);
    int n0, s, o, lim;
    logic [33:0] w, h;
    n0 = expected_words.size();
    case (cmd)
      CMD_FIND: begin
        s = lookup(k);
        if (s < 0) push_word(RES_FIND, 1'b0, '0, '0);
        else begin
          for (int i = 0; i < ENTRIES; i++)
            if (c_valid[i] && c_rank[i] < c_rank[s]) c_rank[i]++;
          c_rank[s] = 0;
          push_word(RES_FIND, 1'b1, c_handle[s], c_key[s]);
        end
      end
      CMD_INSERT: begin
        w = (34'(wd) > 34'(MAX_DIM)) ? 34'(MAX_DIM) : 34'(wd);
        h = (34'(ht) > 34'(MAX_DIM)) ? 34'(MAX_DIM) : 34'(ht);
        lim = (lim_entries < ENTRIES) ? int'(lim_entries) : ENTRIES;
        s = lookup(k);
        if (s >= 0) drop_slot(s);
        if (c_count >= ENTRIES) begin
          o = oldest_slot();
          if (o >= 0) drop_slot(o);
        end
        s = -1;
        for (int i = 0; i < ENTRIES && s < 0; i++)
          if (!c_valid[i]) s = i;
        if (s >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (c_valid[i]) c_rank[i]++;
          c_valid[s] = 1'b1;
          c_rank[s] = 0;
          c_key[s] = k;
          c_handle[s] = 32'(64'(hd) & HANDLE_MASK);
          c_bytes[s] = w * h * 34'd4;
          c_count++;
          c_total += c_bytes[s];
        end
        while (c_count > 0 && (c_count > lim || c_total > {2'b0, lim_bytes})) begin
          o = oldest_slot();
          if (o < 0) break;
          drop_slot(o);
        end
        if (expected_words.size() == n0) push_word(RES_DONE, 1'b0, '0, '0);
      end
      CMD_CLEAR: begin
        // releases go out most recent first
        for (int r = 0; r < ENTRIES; r++)
          for (int i = 0; i < ENTRIES; i++)
            if (c_valid[i] && c_rank[i] == r)
              push_word(RES_RELEASE, 1'b0, c_handle[i], c_key[i]);
        for (int i = 0; i < ENTRIES; i++) begin
          c_valid[i] = 1'b0;
          c_rank[i] = 0;
        end
        c_count = 0;
        c_total = '0;
        if (expected_words.size() == n0) push_word(RES_DONE, 1'b0, '0, '0);
      end
      default: push_word(RES_DONE, 1'b0, '0, '0);
    endcase
    expected_words[expected_words.size() - 1].last = 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    word_t e;
    if (!rst_ni) begin
      fail_count <= 0;
      lim_entries = 6'd32;
      lim_bytes = 32'd100663296;
      for (int i = 0; i < ENTRIES; i++) begin
        c_valid[i] = 1'b0;
        c_rank[i] = 0;
      end
      c_count = 0;
      c_total = '0;
      expected_words.delete();
    end else begin
      if (result_valid_o) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word kind=%0d", result_kind_o);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (result_kind_o !== e.kind || hit_o !== e.hit || out_handle_o !== e.handle ||
              out_key_o !== e.key || last_o !== e.last) begin
            fail_count <= fail_count + 1;
            if (result_kind_o !== e.kind)
              $error("result_kind expected %0d actual %0d", e.kind, result_kind_o);
            if (hit_o !== e.hit) $error("hit expected %0d actual %0d", e.hit, hit_o);
            if (out_handle_o !== e.handle)
              $error("out_handle expected %h actual %h", e.handle, out_handle_o);
            if (out_key_o !== e.key)
              $error("out_key expected %h actual %h", e.key, out_key_o);
            if (last_o !== e.last) $error("last expected %0d actual %0d", e.last, last_o);
          end
        end
      end
      if (start && !busy)
        predict_cache(cmd_e'(command_i), key_i, handle_i, width_i, height_i);
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_MAX_ENTRIES) lim_entries = pwdata[5:0];
        else if (paddr == ADDR_MAX_BYTES) lim_bytes = pwdata;
      end
    end
  end

endmodule

FILE: tb/lru_cache_with_byte_budget_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_with_byte_budget_core_tb
// Drives finds, inserts, clears and nops into the LRU cache over several limit
// settings, with random gaps; a checker module predicts and compares words.
// ----------------------------------------------------------------------------
module lru_cache_with_byte_budget_core_tb;
  import lcbb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam logic [2:0] ADDR_MAX_ENTRIES = 3'd0;
  localparam logic [2:0] ADDR_MAX_BYTES   = 3'd4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = '0;
  logic [63:0] key_i = '0;
  logic [31:0] handle_i = '0;
  logic [13:0] width_i = '0;
  logic [13:0] height_i = '0;
  logic        result_valid_o;
  logic [1:0]  result_kind_o;
  logic        hit_o;
  logic [31:0] out_handle_o;
  logic [63:0] out_key_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_words;
  int          quiet_cycles;
  logic [63:0] key_pool[8];

  always #5 clk_i = ~clk_i;

  lru_cache_with_byte_budget_core u_top (.*);

  lcbb_scoreboard u_chk (.*);

  // watchdog: cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lru_cache_with_byte_budget_core_tb failed");
      $finish;
    end
  end
  initial quiet_cycles = 0;

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(10, 60));
    return int'($urandom_range(0, 3));
  endfunction

  task automatic issue(cmd_e cmd, logic [63:0] k, logic [31:0] hd, logic [13:0] w,
                       logic [13:0] h, bit gaps);
    int n;
    start <= 1'b1;
    command_i <= cmd;
    key_i <= k;
    handle_i <= hd;
    width_i <= w;
    height_i <= h;
    // busy is settled at the falling edge; the word is taken at the next rising edge
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    if (gaps && $urandom_range(0, 2) != 0) begin
      n = gap_len();
      if (n > 0) begin
        start <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || pending_words != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [2:0] a, logic [31:0] d);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int count, int dim_hi);
    logic [63:0] k;
    int r;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                      : key_pool[3'($urandom_range(0, 7))];
      r = $urandom_range(0, 99);
      if (r < 45) issue(CMD_FIND, k, $urandom, 14'($urandom), 14'($urandom), 1);
      else if (r < 92)
        issue(CMD_INSERT, k, $urandom, 14'($urandom_range(0, dim_hi)),
              14'($urandom_range(0, dim_hi)), 1);
      else if (r < 97) issue(CMD_CLEAR, k, $urandom, 14'($urandom), 14'($urandom), 1);
      else issue(CMD_NOP, k, $urandom, 14'($urandom), 14'($urandom), 1);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: miss, hit, reinsert, extreme dims, nop, clear of empty
    issue(CMD_FIND, '0, '0, '0, '0, 0);
    issue(CMD_CLEAR, '0, '0, '0, '0, 0);
    issue(CMD_INSERT, '0, '1, 14'h3FFF, 14'h3FFF, 0);
    issue(CMD_INSERT, '1, 32'h0, 14'd8192, 14'd8192, 0);
    issue(CMD_INSERT, 64'h5555_AAAA_5555_AAAA, 32'hA5A5_5A5A, 14'd1, 14'd0, 0);
    issue(CMD_FIND, '1, '0, '0, '0, 0);
    issue(CMD_FIND, 64'h5555_AAAA_5555_AAAA, '0, '0, '0, 0);
    issue(CMD_INSERT, '1, 32'h1234, 14'd10, 14'd10, 0);
    issue(CMD_NOP, '1, '1, '1, '1, 0);
    for (int i = 0; i < 34; i++) issue(CMD_INSERT, 64'(i + 100), 32'(i), 14'd1, 14'd1, 0);
    issue(CMD_CLEAR, '0, '0, '0, '0, 0);
    wait_drained();

    write_limit(ADDR_MAX_ENTRIES, 32'd63);
    write_limit(ADDR_MAX_BYTES, 32'hFFFF_FFFF);
    random_phase(70, 8192);
    wait_drained();

    write_limit(ADDR_MAX_ENTRIES, 32'd4);
    write_limit(ADDR_MAX_BYTES, 32'd4096);
    random_phase(70, 40);
    wait_drained();

    write_limit(ADDR_MAX_ENTRIES, 32'd1);
    write_limit(ADDR_MAX_BYTES, 32'd0);
    random_phase(40, 3);
    wait_drained();

    write_limit(ADDR_MAX_ENTRIES, 32'd0);
    random_phase(20, 3);
    wait_drained();

    write_limit(ADDR_MAX_ENTRIES, 32'd12);
    write_limit(ADDR_MAX_BYTES, 32'd25165824);
    random_phase(100, 2048);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) $display("lru_cache_with_byte_budget_core_tb passed");
    else $display("lru_cache_with_byte_budget_core_tb failed");
    $finish;
  end

endmodule
